### src/lws_pkg.sv
// Shared types and constants of the lattice walk stepper.
package lws_pkg;

  localparam int COLS = 64;
  localparam int ROW_CAP = 64;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [2:0] ST_MOVED = 3'd0;
  localparam logic [2:0] ST_BLOCKED = 3'd1;
  localparam logic [2:0] ST_STUCK = 3'd2;
  localparam logic [2:0] ST_STARTED = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_NOT_STARTED = 3'd5;

  localparam logic [1:0] HD_UP = 2'd0;
  localparam logic [1:0] HD_LEFT = 2'd1;
  localparam logic [1:0] HD_DOWN = 2'd2;
  localparam logic [1:0] HD_RIGHT = 2'd3;

  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_AVOID_MODE = 2'd1;
  localparam logic [1:0] CFG_RUN_LENGTH = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] random_word;
    logic [5:0]  start_row;
    logic [5:0]  start_col;
  } lws_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] heading;
  } lws_out_t;

  typedef struct packed {
    logic            clr;
    logic            rd_en;
    logic [5:0]      rd_row;
    logic            wr_en;
    logic [5:0]      wr_row;
    logic [COLS-1:0] wr_data;
  } lws_map_req_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } lws_seq_st_t;

endpackage

### src/lws_map.sv
// Visited bitmap: one row word per grid row, per-row valid bits so a clear needs no pass over the memory.
module lws_map import lws_pkg::*; #(
  parameter int ROWS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lws_map_req_t    req,
  output logic [COLS-1:0] rd_data
);

  localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [ROWS-1:0] row_vld_nxt;
  logic [COLS-1:0] rd_raw_r;
  logic            rd_vld_r;
  logic [IW-1:0]   rd_idx;
  logic [IW-1:0]   wr_idx;

  assign rd_idx = req.rd_row[IW-1:0];
  assign wr_idx = req.wr_row[IW-1:0];

  always_comb begin
    row_vld_nxt = row_vld_r;
    if (req.clr) begin
      row_vld_nxt = '0;
    end
    if (req.wr_en) begin
      row_vld_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      row_vld_r <= row_vld_nxt;
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

### src/lws_seq.sv
// Walker state and the sequencer that reads neighbor rows and resolves each item.
module lws_seq import lws_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_take,
  input  lws_in_t         in_item,
  input  logic [6:0]      side,
  input  logic            avoid,
  input  logic [15:0]     run_length,
  input  logic            slot_free,
  input  logic [COLS-1:0] rd_data,
  output lws_map_req_t    map_req,
  output lws_seq_st_t     st,
  output lws_out_t        res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_UP = 3'd1;
  localparam logic [2:0] S_RD_MID = 3'd2;
  localparam logic [2:0] S_RD_DN = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [5:0]      row_r, row_nxt;
  logic [5:0]      col_r, col_nxt;
  logic [1:0]      hd_r, hd_nxt;
  logic [15:0]     run_r, run_nxt;
  logic            started_r, started_nxt;
  logic [1:0]      head_r, head_nxt;
  logic [15:0]     left_r, left_nxt;
  logic [COLS-1:0] up_r, up_nxt;
  logic [COLS-1:0] mid_r, mid_nxt;

  logic [3:0]      wall_ok;
  logic [3:0]      open;
  logic [5:0]      c_m1, c_p1, r_m1, r_p1;
  logic            can_move;
  logic            start_ok;

  assign r_m1 = row_r - 6'd1;
  assign r_p1 = row_r + 6'd1;
  assign c_m1 = col_r - 6'd1;
  assign c_p1 = col_r + 6'd1;

  assign wall_ok[HD_UP] = (row_r != 6'd0);
  assign wall_ok[HD_LEFT] = (col_r != 6'd0);
  assign wall_ok[HD_DOWN] = (({1'b0, row_r} + 7'd1) < side);
  assign wall_ok[HD_RIGHT] = (({1'b0, col_r} + 7'd1) < side);

  assign open[HD_UP] = wall_ok[HD_UP] & ~up_r[col_r];
  assign open[HD_LEFT] = wall_ok[HD_LEFT] & ~mid_r[c_m1];
  assign open[HD_DOWN] = wall_ok[HD_DOWN] & ~rd_data[col_r];
  assign open[HD_RIGHT] = wall_ok[HD_RIGHT] & ~mid_r[c_p1];

  assign can_move = avoid ? open[head_r] : wall_ok[head_r];
  assign start_ok = ({1'b0, in_item.start_row} < side) && ({1'b0, in_item.start_col} < side);

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    col_nxt = col_r;
    hd_nxt = hd_r;
    run_nxt = run_r;
    started_nxt = started_r;
    head_nxt = head_r;
    left_nxt = left_r;
    up_nxt = up_r;
    mid_nxt = mid_r;
    map_req = '0;
    st.idle = (state_r == S_IDLE);
    st.res_valid = 1'b0;
    res.status = ST_MOVED;
    res.row = row_r;
    res.col = col_r;
    res.heading = hd_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_item.command == CMD_START) begin
            st.res_valid = 1'b1;
            if (start_ok) begin
              map_req.clr = 1'b1;
              map_req.wr_en = 1'b1;
              map_req.wr_row = in_item.start_row;
              map_req.wr_data = {{(COLS-1){1'b0}}, 1'b1} << in_item.start_col;
              row_nxt = in_item.start_row;
              col_nxt = in_item.start_col;
              hd_nxt = HD_UP;
              run_nxt = run_length;
              started_nxt = 1'b1;
              res.status = ST_STARTED;
              res.row = in_item.start_row;
              res.col = in_item.start_col;
              res.heading = HD_UP;
            end else begin
              res.status = ST_REJECTED;
            end
          end else if (!started_r) begin
            st.res_valid = 1'b1;
            res.status = ST_NOT_STARTED;
          end else begin
            if (run_r != 16'd0) begin
              left_nxt = run_r - 16'd1;
              head_nxt = hd_r;
            end else begin
              left_nxt = run_length;
              head_nxt = in_item.random_word[1:0] + 2'd1;
            end
            state_nxt = S_RD_UP;
          end
        end
      end
      S_RD_UP: begin
        map_req.rd_en = wall_ok[HD_UP];
        map_req.rd_row = r_m1;
        state_nxt = S_RD_MID;
      end
      S_RD_MID: begin
        up_nxt = rd_data;
        map_req.rd_en = 1'b1;
        map_req.rd_row = row_r;
        state_nxt = S_RD_DN;
      end
      S_RD_DN: begin
        mid_nxt = rd_data;
        map_req.rd_en = wall_ok[HD_DOWN];
        map_req.rd_row = r_p1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (slot_free) begin
          st.res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (can_move) begin
            map_req.wr_en = 1'b1;
            case (head_r)
              HD_UP: begin
                row_nxt = r_m1;
                map_req.wr_row = r_m1;
                map_req.wr_data = up_r | ({{(COLS-1){1'b0}}, 1'b1} << col_r);
              end
              HD_LEFT: begin
                col_nxt = c_m1;
                map_req.wr_row = row_r;
                map_req.wr_data = mid_r | ({{(COLS-1){1'b0}}, 1'b1} << c_m1);
              end
              HD_DOWN: begin
                row_nxt = r_p1;
                map_req.wr_row = r_p1;
                map_req.wr_data = rd_data | ({{(COLS-1){1'b0}}, 1'b1} << col_r);
              end
              default: begin
                col_nxt = c_p1;
                map_req.wr_row = row_r;
                map_req.wr_data = mid_r | ({{(COLS-1){1'b0}}, 1'b1} << c_p1);
              end
            endcase
            hd_nxt = head_r;
            run_nxt = left_r;
            res.status = ST_MOVED;
          end else if (avoid && (open == 4'd0)) begin
            res.status = ST_STUCK;
          end else begin
            hd_nxt = head_r;
            run_nxt = 16'd0;
            res.status = ST_BLOCKED;
          end
          res.row = row_nxt;
          res.col = col_nxt;
          res.heading = hd_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r <= 6'd0;
      col_r <= 6'd0;
      hd_r <= HD_UP;
      run_r <= 16'd0;
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      hd_r <= hd_nxt;
      run_r <= run_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    left_r <= left_nxt;
    up_r <= up_nxt;
    mid_r <= mid_nxt;
  end

endmodule

### src/lattice_walk_stepper_top.sv
// Top level of the lattice walk stepper: configuration, bitmap, sequencer, result register.
//
// A start item, a rejected start and a step before any start are each resolved in the
// cycle they are taken; a valid start clears the whole visited bitmap through per-row
// valid bits, so no clearing pass follows reset or start. For a step item the single
// read port of the bitmap memory reads the rows above, at and below the walker, one per
// cycle, and a final state resolves the move and writes the marked row back. One item
// is in work at a time; a finished result waits in the output register. The user must
// write configuration only while the block is idle; the block does not enforce this.
module lattice_walk_stepper_top import lws_pkg::*; #(
  parameter int GRID_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lws_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output lws_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int ROWS = (GRID_MAX < ROW_CAP) ? GRID_MAX : ROW_CAP;
  localparam logic [6:0] SIDE_MAX = 7'(ROWS);

  logic [6:0]      grid_size_r;
  logic            avoid_mode_r;
  logic [15:0]     run_length_r;
  logic [6:0]      side;
  logic            out_valid_r;
  lws_out_t        out_data_r;
  logic            slot_free;
  logic            in_take;
  lws_map_req_t    map_req;
  lws_seq_st_t     seq_st;
  lws_out_t        res;
  logic [COLS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= 7'd16;
      avoid_mode_r <= 1'b0;
      run_length_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size_r <= cfg_wdata[6:0];
        CFG_AVOID_MODE: avoid_mode_r <= cfg_wdata[0];
        CFG_RUN_LENGTH: run_length_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (grid_size_r < 7'd2) begin
      side = 7'd2;
    end else if (grid_size_r > SIDE_MAX) begin
      side = SIDE_MAX;
    end else begin
      side = grid_size_r;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall = !(seq_st.idle && slot_free);
  assign in_take = in_valid && !in_stall;

  lws_map #(
    .ROWS(ROWS)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_data (rd_data)
  );

  lws_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_item    (in_data),
    .side       (side),
    .avoid      (avoid_mode_r),
    .run_length (run_length_r),
    .slot_free  (slot_free),
    .rd_data    (rd_data),
    .map_req    (map_req),
    .st         (seq_st),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_st.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_st.res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_st.res_valid |-> slot_free)
    else $error("result produced while output register still held");

  a_item_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (!seq_st.idle || out_valid_r))
    else $error("accepted item neither in work nor delivered");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status <= ST_NOT_STARTED))
    else $error("result status out of range");
`endif

endmodule

### tb/lattice_walk_stepper_top_tb.sv
// Self-checking testbench of the lattice walk stepper: directed walks, random walks, back-pressure.
module lattice_walk_stepper_top_tb import lws_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX = 64;
  localparam int unsigned SIDE_CAP = (GRID_MAX < COLS) ? GRID_MAX : COLS;
  localparam int QUIET_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  lws_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  lws_out_t    out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  lattice_walk_stepper_top #(.GRID_MAX(GRID_MAX)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [COLS-1:0] visit_map [ROW_CAP];
  logic [5:0]      walker_r;
  logic [5:0]      walker_c;
  logic [1:0]      walker_head;
  logic [15:0]     run_cnt;
  logic            walking;
  logic [6:0]      grid_reg;
  logic            avoid_reg;
  logic [15:0]     run_reg;

  lws_out_t walk_results_q [$];
  int       err_count = 0;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_left;
  int       quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned grid_side();
    int unsigned s;
    s = 32'(grid_reg);
    if (s > SIDE_CAP) s = SIDE_CAP;
    if (s < 2) s = 2;
    return s;
  endfunction

  function automatic lws_out_t walk_step(lws_in_t it);
    int unsigned side;
    logic [5:0]  r;
    logic [5:0]  c;
    logic [1:0]  head;
    logic [15:0] left;
    logic [3:0]  wall_ok;
    logic [3:0]  open;
    lws_out_t    res;
    side = grid_side();
    if (it.command == CMD_START) begin
      if (32'(it.start_row) >= side || 32'(it.start_col) >= side) begin
        res.status = ST_REJECTED;
      end else begin
        for (int i = 0; i < ROW_CAP; i++) visit_map[i] = '0;
        walker_r = it.start_row;
        walker_c = it.start_col;
        visit_map[walker_r][walker_c] = 1'b1;
        walker_head = HD_UP;
        run_cnt = run_reg;
        walking = 1'b1;
        res.status = ST_STARTED;
      end
    end else if (!walking) begin
      res.status = ST_NOT_STARTED;
    end else begin
      r = walker_r;
      c = walker_c;
      if (run_cnt != 16'd0) begin
        left = run_cnt - 16'd1;
        head = walker_head;
      end else begin
        left = run_reg;
        head = it.random_word[1:0] + 2'd1;
      end
      wall_ok[HD_UP]    = (r != 6'd0);
      wall_ok[HD_LEFT]  = (c != 6'd0);
      wall_ok[HD_DOWN]  = (32'(r) + 32'd1 < side);
      wall_ok[HD_RIGHT] = (32'(c) + 32'd1 < side);
      open[HD_UP]    = wall_ok[HD_UP]    ? !visit_map[r - 6'd1][c] : 1'b0;
      open[HD_LEFT]  = wall_ok[HD_LEFT]  ? !visit_map[r][c - 6'd1] : 1'b0;
      open[HD_DOWN]  = wall_ok[HD_DOWN]  ? !visit_map[r + 6'd1][c] : 1'b0;
      open[HD_RIGHT] = wall_ok[HD_RIGHT] ? !visit_map[r][c + 6'd1] : 1'b0;
      if (avoid_reg ? open[head] : wall_ok[head]) begin
        case (head)
          HD_UP:   r = r - 6'd1;
          HD_LEFT: c = c - 6'd1;
          HD_DOWN: r = r + 6'd1;
          default: c = c + 6'd1;
        endcase
        walker_r = r;
        walker_c = c;
        visit_map[walker_r][walker_c] = 1'b1;
        walker_head = head;
        run_cnt = left;
        res.status = ST_MOVED;
      end else if (avoid_reg && open == 4'b0000) begin
        res.status = ST_STUCK;
      end else begin
        walker_head = head;
        run_cnt = '0;
        res.status = ST_BLOCKED;
      end
    end
    res.row = walker_r;
    res.col = walker_c;
    res.heading = walker_head;
    return res;
  endfunction

  task automatic field_check(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    lws_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (walk_results_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h", $time, out_data);
        err_count++;
      end else begin
        exp_res = walk_results_q.pop_front();
        field_check("status", 32'(exp_res.status), 32'(out_data.status));
        field_check("row", 32'(exp_res.row), 32'(out_data.row));
        field_check("col", 32'(exp_res.col), 32'(out_data.col));
        field_check("heading", 32'(exp_res.heading), 32'(out_data.heading));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("lattice_walk_stepper_top_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(lws_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    walk_results_q.push_back(walk_step(it));
  endtask

  task automatic send_start(int unsigned r, int unsigned c);
    lws_in_t it;
    it.command = CMD_START;
    it.random_word = 16'($urandom);
    it.start_row = 6'(r);
    it.start_col = 6'(c);
    send_item(it);
  endtask

  task automatic send_step(logic [15:0] word);
    lws_in_t it;
    it.command = CMD_STEP;
    it.random_word = word;
    it.start_row = 6'($urandom);
    it.start_col = 6'($urandom);
    send_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GRID_SIZE:  grid_reg = val[6:0];
      CFG_AVOID_MODE: avoid_reg = val[0];
      CFG_RUN_LENGTH: run_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] g;
    logic [15:0] rl;
    case ($urandom_range(9))
      0:       g = 16'($urandom_range(1));
      1:       g = 16'd64;
      2:       g = 16'($urandom_range(127, 65));
      3, 4:    g = 16'($urandom_range(4, 2));
      default: g = 16'($urandom_range(64, 2));
    endcase
    case ($urandom_range(7))
      0:       rl = 16'hFFFF;
      1:       rl = 16'($urandom);
      default: rl = 16'($urandom_range(4));
    endcase
    write_cfg(CFG_GRID_SIZE, g);
    write_cfg(CFG_AVOID_MODE, 16'($urandom_range(1)));
    write_cfg(CFG_RUN_LENGTH, rl);
  endtask

  task automatic test_reset_walls();
    send_step(16'hFFFF);
    send_start(16, 0);
    send_start(63, 63);
    send_start(15, 15);
    send_step(16'd2);
    send_step(16'd1);
    send_step(16'd3);
    wait_drained();
  endtask

  task automatic test_stuck_tiny_grid();
    write_cfg(CFG_GRID_SIZE, 16'd0);
    write_cfg(CFG_AVOID_MODE, 16'd1);
    send_start(0, 0);
    send_step(16'd2);
    send_step(16'd1);
    send_step(16'd0);
    send_step(16'd3);
    send_start(0, 2);
    wait_drained();
  endtask

  task automatic test_run_length();
    write_cfg(CFG_GRID_SIZE, 16'd127);
    write_cfg(CFG_RUN_LENGTH, 16'd3);
    send_start(63, 63);
    send_step(16'd3);
    send_step(16'd0);
    send_step(16'd1);
    send_step(16'd2);
    send_step(16'd1);
    write_cfg(CFG_RUN_LENGTH, 16'hFFFF);
    send_start(0, 0);
    send_step(16'hFFFF);
    send_step(16'd2);
    wait_drained();
  endtask

  task automatic test_grid_shrink();
    write_cfg(CFG_GRID_SIZE, 16'd16);
    write_cfg(CFG_AVOID_MODE, 16'd0);
    write_cfg(CFG_RUN_LENGTH, 16'd0);
    send_start(10, 10);
    write_cfg(CFG_GRID_SIZE, 16'd4);
    send_step(16'd1);
    send_step(16'd3);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_GRID_SIZE, 16'd8);
    write_cfg(CFG_AVOID_MODE, 16'd1);
    hold_left = 300;
    send_start(3, 3);
    repeat (12) send_step(16'($urandom));
    wait_drained();
    repeat (8) send_step(16'($urandom));
    wait_drained();
  endtask

  task automatic test_random_walks(int n_items, int s_pct, int r_pct);
    int      sent;
    lws_in_t it;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 40) random_config();
      if ($urandom_range(9) == 0) begin
        send_start($urandom_range(63), $urandom_range(63));
      end else begin
        send_start($urandom_range(grid_side() - 1), $urandom_range(grid_side() - 1));
      end
      sent++;
      repeat ($urandom_range(40, 5)) begin
        it.command = ($urandom_range(19) == 0) ? CMD_START : CMD_STEP;
        it.random_word = 16'($urandom);
        it.start_row = 6'($urandom);
        it.start_col = 6'($urandom);
        send_item(it);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_SIZE;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    for (int i = 0; i < ROW_CAP; i++) visit_map[i] = '0;
    walker_r = '0;
    walker_c = '0;
    walker_head = HD_UP;
    run_cnt = '0;
    walking = 1'b0;
    grid_reg = 7'd16;
    avoid_reg = 1'b0;
    run_reg = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_walls();
    test_stuck_tiny_grid();
    test_run_length();
    test_grid_shrink();
    test_backpressure();
    test_random_walks(400, 27, 61);
    test_random_walks(400, 61, 27);
    test_random_walks(400, 0, 0);

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("lattice_walk_stepper_top_tb: PASS");
    end else begin
      $display("lattice_walk_stepper_top_tb: FAIL");
    end
    $finish;
  end

endmodule
